>>> design/assert_macros.svh
// assertion macros shared by the servo pulse sequencer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SVPS_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// consequent holds at the next clock edge after the antecedent
`define SVPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/svps_pkg.sv
// shared types, codes and constants of the servo pulse sequencer
// no dependencies; imported by svps_core and servo_pulse_sequencer
package svps_pkg;

   // field widths of one beat
   localparam int CMD_W    = 3;
   localparam int CH_W     = 4;
   localparam int WIDTH_W  = 16;
   localparam int LEVEL_W  = 8;
   localparam int READ_W   = 13;
   localparam int CFG_W    = 12;
   localparam int FSO_W    = 8;
   localparam int TICK_W   = 8;
   localparam int COARSE_W = 5;
   localparam int FINE_W   = 8;
   localparam int CSR_IDX_W = 2;

   // defaults
   localparam int DEF_CHANNELS = 8;
   localparam logic [COARSE_W-1:0] COARSE_RESET = COARSE_W'(11);
   localparam logic [FINE_W-1:0]   FINE_RESET   = FINE_W'(87);
   localparam logic [CFG_W-1:0]    MIN_RESET    = CFG_W'(750);
   localparam logic [CFG_W-1:0]    MAX_RESET    = CFG_W'(2250);
   localparam logic [FSO_W-1:0]    FSO_RESET    = FSO_W'(5);
   localparam logic [CFG_W-1:0]    WIDTH_ADJUST = CFG_W'(8);
   localparam logic [FINE_W-1:0]   FINE_TOP     = FINE_W'(255);

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_ATTACH = 3'd2,
      CMD_DETACH = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_SYNC = 2'd2;

   // input beat, cmd in the lowest bits
   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic [CH_W-1:0]    channel;
      logic [CMD_W-1:0]   cmd;
   } item_type;

   // result beat, pulse_levels in the lowest bits
   typedef struct packed {
      logic               accepted;
      logic               channel_active;
      logic [READ_W-1:0]  read_width;
      logic [LEVEL_W-1:0] pulse_levels;
   } result_type;

   // configuration registers
   typedef struct packed {
      logic [CFG_W-1:0] min_width;
      logic [CFG_W-1:0] max_width;
      logic [FSO_W-1:0] frame_sync_overflows;
   } cfg_type;

   localparam int ITEM_W     = $bits(item_type);
   localparam int RESULT_W   = $bits(result_type);
   localparam int REQ_DATA_W = ((ITEM_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> design/svps_core.sv
// pulse timing state and per-beat command logic of the servo pulse sequencer
// depends on svps_pkg and assert_macros.svh
`include "assert_macros.svh"

module svps_core import svps_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] LAST_SLOT = CH_W'(CHANNELS);

   // timing state
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [FSO_W-1:0]    ovf_ff, ovf_in;
   logic [CH_W-1:0]     slot_ff, slot_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [CHANNELS-1:0] active_ff, active_in;

   // per-channel widths
   logic [COARSE_W-1:0] coarse_ff [CHANNELS];
   logic [FINE_W-1:0]   fine_ff [CHANNELS];

   logic                is_tick, ch_ok, slot0, wrap, wr_en;
   logic [CH_W-1:0]     ch_m1, slot_m1, slot_nx;
   logic [IDX_W-1:0]    ch_idx, rd_idx;
   logic [COARSE_W-1:0] coarse_rd, coarse_wr;
   logic [FINE_W-1:0]   fine_rd, fine_wr, reload;
   logic [FSO_W-1:0]    limit, ovf_inc;
   logic [LEVEL_W-1:0]  clr_mask, set_mask, act_lvl;
   logic [LEVEL_W+CHANNELS-1:0] act_ext;
   logic [CFG_W-1:0]    w_cl, w_adj;
   logic [READ_W-1:0]   rd_width;

   // decode and table read, one address per beat
   assign is_tick = (item.cmd == CMD_TICK);
   assign ch_ok   = (item.channel != '0) && (item.channel <= LAST_SLOT);
   assign ch_m1   = item.channel - CH_W'(1);
   assign slot_m1 = slot_ff - CH_W'(1);
   assign ch_idx  = ch_m1[IDX_W-1:0];
   assign rd_idx  = is_tick ? slot_m1[IDX_W-1:0] : ch_idx;
   assign coarse_rd = coarse_ff[rd_idx];
   assign fine_rd   = fine_ff[rd_idx];

   // slot limits, frame sync slot has no fine part
   assign slot0   = (slot_ff == '0);
   assign limit   = slot0 ? cfg.frame_sync_overflows : FSO_W'(coarse_rd);
   assign reload  = slot0 ? '0 : fine_rd;
   assign wrap    = &tick_ff;
   assign ovf_inc = ovf_ff + FSO_W'(1);
   assign slot_nx = (slot_ff == LAST_SLOT) ? '0 : slot_ff + CH_W'(1);

   // level edges at the end of a slot, only for attached channels with a pin bit
   assign act_ext = {{LEVEL_W{1'b0}}, active_ff};
   assign act_lvl = act_ext[LEVEL_W-1:0];
   always_comb begin
      for (int b = 0; b < LEVEL_W; b++) begin
         clr_mask[b] = (slot_ff == CH_W'(b + 1)) && act_lvl[b];
         set_mask[b] = (slot_nx == CH_W'(b + 1)) && act_lvl[b];
      end
   end

   // width clamp and split into coarse count and fine reload
   always_comb begin
      if (item.width < WIDTH_W'(cfg.min_width)) begin
         w_cl = cfg.min_width;
      end else if (item.width > WIDTH_W'(cfg.max_width)) begin
         w_cl = cfg.max_width;
      end else begin
         w_cl = item.width[CFG_W-1:0];
      end
      w_adj = (w_cl >= WIDTH_ADJUST) ? w_cl - WIDTH_ADJUST : '0;
   end
   assign coarse_wr = w_adj[CFG_W-1:CFG_W-COARSE_W];
   assign fine_wr   = FINE_TOP - {w_adj[CFG_W-COARSE_W-1:0], 1'b0};

   // next state
   always_comb begin
      tick_in   = tick_ff;
      ovf_in    = ovf_ff;
      slot_in   = slot_ff;
      level_in  = level_ff;
      active_in = active_ff;
      wr_en     = 1'b0;
      if (step) begin
         case (item.cmd)
            CMD_TICK: begin
               tick_in = tick_ff + TICK_W'(1);
               if (wrap) begin
                  ovf_in = ovf_inc;
                  if (ovf_inc == limit) begin
                     tick_in = reload;
                  end else if (ovf_inc > limit) begin
                     ovf_in   = '0;
                     tick_in  = '0;
                     slot_in  = slot_nx;
                     level_in = (level_ff & ~clr_mask) | set_mask;
                  end
               end
            end
            CMD_WRITE: begin
               wr_en = ch_ok;
            end
            CMD_ATTACH: begin
               if (ch_ok) active_in[ch_idx] = 1'b1;
            end
            CMD_DETACH: begin
               if (ch_ok) active_in[ch_idx] = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // reconstructed width for a read
   always_comb begin
      rd_width = '0;
      if (item.cmd == CMD_READ && ch_ok) begin
         rd_width = {coarse_rd, 7'b0} + READ_W'((FINE_TOP - fine_rd) >> 1)
                  + READ_W'(WIDTH_ADJUST);
      end
   end

   // result of this beat, taken from the state after it
   always_comb begin
      result.pulse_levels   = level_in;
      result.read_width     = rd_width;
      result.channel_active = ch_ok && active_in[ch_idx];
      result.accepted       = is_tick || (ch_ok && (item.cmd <= CMD_READ));
   end

   // timing state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         ovf_ff    <= '0;
         slot_ff   <= '0;
         level_ff  <= '0;
         active_ff <= '0;
      end else begin
         tick_ff   <= tick_in;
         ovf_ff    <= ovf_in;
         slot_ff   <= slot_in;
         level_ff  <= level_in;
         active_ff <= active_in;
      end
   end

   // width table, 1500 us default in every channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            coarse_ff[i] <= COARSE_RESET;
            fine_ff[i]   <= FINE_RESET;
         end
      end else if (wr_en) begin
         coarse_ff[ch_idx] <= coarse_wr;
         fine_ff[ch_idx]   <= fine_wr;
      end
   end

   `SVPS_ASSERT_ALWAYS(a_slot_range, clock, reset, slot_ff <= LAST_SLOT,
      "slot beyond last channel")
   `SVPS_ASSERT_NEXT(a_slot_end_clears, clock, reset,
      step && is_tick && (slot_in != slot_ff), (ovf_ff == '0) && (tick_ff == '0),
      "slot change did not clear the counters")
   `SVPS_ASSERT_NEXT(a_counters_hold, clock, reset, !(step && is_tick),
      $stable(tick_ff) && $stable(ovf_ff) && $stable(slot_ff) && $stable(level_ff),
      "timing state moved without a tick")

endmodule

>>> design/servo_pulse_sequencer.sv
// top level of the servo pulse sequencer: stream ports, csr, input and result stages
// depends on svps_pkg, svps_core and assert_macros.svh
//
// channel   direction  handshake             payload
// req_      in         req_tvalid/tready     req_tdata: cmd, channel, width
// rsp_      out        rsp_tvalid/tready     rsp_tdata: levels, read width, active, accepted
// csr_      in         csr_we (no wait)      csr_index, csr_wdata
//
// one beat per cycle sustained while rsp_tready stays high; a beat waits in the input register
// and its result, set by the single command stage, is registered in the output register or skid
// results sit in an output register with a one-entry skid, so req_tready only
// drops when both are full and the input register holds a beat
// synchronous active-high reset restores default widths, registers and counters
// at once; no clearing pass
`include "assert_macros.svh"

module servo_pulse_sequencer import svps_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // cmd[2:0], channel[6:3], width[22:7]
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // pulse_levels[7:0], read_width[20:8],
                                             // channel_active[21], accepted[22]
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type    cfg_ff;
   item_type   in_item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type out_data_ff, out_data_in, skid_data_ff, skid_data_in, step_result;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic       req_beat, advance, pop;

   // handshakes
   assign advance    = in_valid_ff && !skid_valid_ff;
   assign req_tready = !in_valid_ff || !skid_valid_ff;
   assign req_beat   = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign in_valid_in = req_beat || (in_valid_ff && !advance);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_width            <= MIN_RESET;
         cfg_ff.max_width            <= MAX_RESET;
         cfg_ff.frame_sync_overflows <= FSO_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_WIDTH:  cfg_ff.min_width            <= csr_wdata;
            CSR_MAX_WIDTH:  cfg_ff.max_width            <= csr_wdata;
            CSR_FRAME_SYNC: cfg_ff.frame_sync_overflows <= csr_wdata[FSO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_item_ff <= req_tdata[ITEM_W-1:0];
      end
   end

   // command stage
   svps_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // output register and skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         out_valid_in  = skid_valid_ff || advance;
         out_data_in   = skid_valid_ff ? skid_data_ff : step_result;
         skid_valid_in = 1'b0;
      end else if (advance) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RESULT_W)'(0), out_data_ff};

   `SVPS_ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff,
      "skid entry held with empty output register")
   `SVPS_ASSERT_NEXT(a_req_lands, clock, reset, req_beat, in_valid_ff,
      "accepted request beat not held in the input register")
   `SVPS_ASSERT_NEXT(a_step_lands, clock, reset, advance,
      out_valid_ff && (!$past(out_valid_ff && !pop) || skid_valid_ff),
      "processed beat lost between the command stage and the output")

endmodule
